@@ hw/rtl/stag_pkg.sv @@
// Package for the sine tone A-law generator: sizes, register indexes,
// reset values, A-law constants and the quarter-wave sine table.
// No dependencies.
package stag_pkg;

   localparam int FRAME_SAMPLES  = 160;
   localparam int SINE_ADDR_BITS = 10;
   localparam int PHASE_BITS     = 32;

   localparam int QUARTER_BITS  = SINE_ADDR_BITS - 2;
   localparam int QUARTER_LEN   = 1 << QUARTER_BITS;
   localparam int ROM_ADDR_BITS = QUARTER_BITS + 1;
   localparam int SIF_BITS      = 8;

   localparam int AMP_BITS    = 15;
   localparam int FRAMES_BITS = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int CSR_IDX_BITS = 2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PHASE_STEP  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AMPLITUDE   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TONE_FRAMES = 2'd2;

   localparam logic [PHASE_BITS-1:0]  PHASE_STEP_RST  = '0;
   localparam logic [AMP_BITS-1:0]    AMPLITUDE_RST   = 15'd16384;
   localparam logic [FRAMES_BITS-1:0] TONE_FRAMES_RST = 16'd1;

   localparam logic [SIF_BITS-1:0] LAST_SIF = SIF_BITS'(FRAME_SAMPLES - 1);

   // A-law even-bit inversion masks
   localparam logic [7:0] ALAW_XMASK_POS = 8'hD5;
   localparam logic [7:0] ALAW_XMASK_NEG = 8'h55;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic [AMP_BITS-1:0] sine_rom_type [0:QUARTER_LEN];

   // round(32767 * sin(k/Q * pi/2)) by a truncated Q30 Taylor series
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type   rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint         s;
      longint         v;
      for (int k = 0; k <= QUARTER_LEN; k++) begin
         x    = (64'(k) * HALF_PI_Q30) / QUARTER_LEN;
         x2   = (x * x) >> 30;
         term = x;
         s    = longint'(x);
         term = ((term * x2) >> 30) / 64'd6;   s = s - longint'(term);
         term = ((term * x2) >> 30) / 64'd20;  s = s + longint'(term);
         term = ((term * x2) >> 30) / 64'd42;  s = s - longint'(term);
         term = ((term * x2) >> 30) / 64'd72;  s = s + longint'(term);
         term = ((term * x2) >> 30) / 64'd110; s = s - longint'(term);
         term = ((term * x2) >> 30) / 64'd156; s = s + longint'(term);
         term = ((term * x2) >> 30) / 64'd210; s = s - longint'(term);
         term = ((term * x2) >> 30) / 64'd272; s = s + longint'(term);
         if (s < 0) begin
            s = 0;
         end
         v = (s * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
         if (v > 64'sd32767) begin
            v = 64'sd32767;
         end
         rom[k] = AMP_BITS'(v);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

@@ hw/rtl/stag_req_if.sv @@
// Tick channel of the sine tone A-law generator.
// Depends on nothing.
interface stag_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

@@ hw/rtl/stag_rsp_if.sv @@
// Sample channel of the sine tone A-law generator.
// Depends on nothing.
interface stag_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        alaw_byte;
   logic signed [15:0] linear_sample;
   logic              last_of_frame;
   logic              last_of_tone;

   modport source (output valid, output alaw_byte, output linear_sample,
                   output last_of_frame, output last_of_tone, input ready);
   modport sink   (input valid, input alaw_byte, input linear_sample,
                   input last_of_frame, input last_of_tone, output ready);
endinterface

@@ hw/rtl/stag_csr_if.sv @@
// Register write channel of the sine tone A-law generator.
// Depends on nothing.
interface stag_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [31:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ hw/rtl/sine_tone_alaw_generator_unit.sv @@
// Sine tone generator with A-law encoder, top level.
// Uses stag_pkg and the stag_req_if, stag_rsp_if and stag_csr_if interfaces.
//
// One tick beat is taken every clock while the output register is free or
// being drained. Each beat of a running tone gives one sample beat, presented
// on the rsp side after the stage 1, stage 2 and output registers.
// The three stages are the sine ROM synchronous read, the 15x15 amplitude
// multiply, and the sign and A-law encode into the output register. The rate is
// set by the single shared stall of this three-stage pipeline: a stalled rsp
// side holds every stage. Ticks while idle give no beat. Registers are written
// whenever the csr channel is valid; write them only while no tone beat is in
// flight.
module sine_tone_alaw_generator_unit
   import stag_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   stag_req_if.sink           req_bus,
   stag_rsp_if.source         rsp_bus,
   stag_csr_if.sink           csr_bus
);

   // configuration
   logic [PHASE_BITS-1:0]  phase_step_ff;
   logic [AMP_BITS-1:0]    amplitude_ff;
   logic [FRAMES_BITS-1:0] tone_frames_ff;

   // tone state
   logic [PHASE_BITS-1:0]  phase_acc_ff,  phase_acc_in;
   logic [SIF_BITS-1:0]    sif_ff,        sif_in;
   logic [FRAMES_BITS-1:0] frames_left_ff, frames_left_in;
   logic                   active_ff,     active_in;

   // stage 0 working values
   logic                   advance;
   logic                   accept;
   logic                   active_now;
   logic [PHASE_BITS-1:0]  phase_cur;
   logic [SIF_BITS-1:0]    sif_cur;
   logic [FRAMES_BITS-1:0] frames_cur;
   logic [FRAMES_BITS-1:0] frames_dec;
   logic [SINE_ADDR_BITS-1:0] sine_addr;
   logic [ROM_ADDR_BITS-1:0]  rom_addr;
   logic                   lof0, lot0;

   // stage 1: ROM data
   logic                   s1_valid_ff;
   logic [AMP_BITS-1:0]    s1_rom_ff;
   logic                   s1_neg_ff, s1_lof_ff, s1_lot_ff;

   // stage 2: scaled magnitude
   logic                   s2_valid_ff;
   logic [AMP_BITS-1:0]    s2_mag_ff;
   logic                   s2_neg_ff, s2_lof_ff, s2_lot_ff;
   logic [2*AMP_BITS-1:0]  scaled;

   // output stage
   logic                   out_valid_ff;
   logic [7:0]             out_alaw_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                   out_lof_ff, out_lot_ff;
   logic signed [SAMPLE_BITS-1:0] sample2;
   logic [SAMPLE_BITS-1:0] mag_lin;
   logic [11:0]            mag12;
   logic [2:0]             seg;
   logic [11:0]            mag_sh;
   logic [7:0]             alaw;

   assign advance     = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign accept      = req_bus.valid && advance;
   assign csr_bus.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= PHASE_STEP_RST;
         amplitude_ff   <= AMPLITUDE_RST;
         tone_frames_ff <= TONE_FRAMES_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            CSR_PHASE_STEP:  phase_step_ff  <= csr_bus.wdata[PHASE_BITS-1:0];
            CSR_AMPLITUDE:   amplitude_ff   <= csr_bus.wdata[AMP_BITS-1:0];
            CSR_TONE_FRAMES: tone_frames_ff <= csr_bus.wdata[FRAMES_BITS-1:0];
            default: ;
         endcase
      end
   end

   // stage 0: tone state and ROM address
   always_comb begin
      active_now = req_bus.restart || active_ff;
      if (req_bus.restart) begin
         phase_cur  = '0;
         sif_cur    = '0;
         frames_cur = (tone_frames_ff == '0) ? FRAMES_BITS'(1) : tone_frames_ff;
      end else begin
         phase_cur  = phase_acc_ff;
         sif_cur    = sif_ff;
         frames_cur = frames_left_ff;
      end
      lof0 = (sif_cur >= LAST_SIF);
      lot0 = lof0 && (frames_cur <= FRAMES_BITS'(1));
      frames_dec = (frames_cur != '0) ? frames_cur - FRAMES_BITS'(1) : '0;

      sine_addr = phase_cur[PHASE_BITS-1 -: SINE_ADDR_BITS];
      if (sine_addr[QUARTER_BITS]) begin
         rom_addr = ROM_ADDR_BITS'(QUARTER_LEN)
                    - {1'b0, sine_addr[QUARTER_BITS-1:0]};
      end else begin
         rom_addr = {1'b0, sine_addr[QUARTER_BITS-1:0]};
      end

      phase_acc_in   = phase_acc_ff;
      sif_in         = sif_ff;
      frames_left_in = frames_left_ff;
      active_in      = active_ff;
      if (accept && active_now) begin
         phase_acc_in = phase_cur + phase_step_ff;
         if (lof0) begin
            sif_in         = '0;
            frames_left_in = frames_dec;
            active_in      = (frames_dec != '0);
         end else begin
            sif_in         = sif_cur + SIF_BITS'(1);
            frames_left_in = frames_cur;
            active_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff   <= '0;
         sif_ff         <= '0;
         frames_left_ff <= '0;
         active_ff      <= 1'b0;
      end else begin
         phase_acc_ff   <= phase_acc_in;
         sif_ff         <= sif_in;
         frames_left_ff <= frames_left_in;
         active_ff      <= active_in;
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept && active_now;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: synchronous sine ROM read
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_rom_ff <= SINE_ROM[rom_addr];
         s1_neg_ff <= sine_addr[SINE_ADDR_BITS-1];
         s1_lof_ff <= lof0;
         s1_lot_ff <= lot0;
      end
   end

   // stage 2: amplitude scaling with rounding, full product fits 30 bits
   assign scaled = {{AMP_BITS{1'b0}}, s1_rom_ff} * {{AMP_BITS{1'b0}}, amplitude_ff}
                   + (2*AMP_BITS)'(16384);

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_mag_ff <= scaled[2*AMP_BITS-1 -: AMP_BITS];
         s2_neg_ff <= s1_neg_ff;
         s2_lof_ff <= s1_lof_ff;
         s2_lot_ff <= s1_lot_ff;
      end
   end

   // stage 3: sign and A-law encode
   always_comb begin
      if (s2_neg_ff) begin
         sample2 = -$signed({1'b0, s2_mag_ff});
      end else begin
         sample2 = $signed({1'b0, s2_mag_ff});
      end
      // magnitude - 1 for negatives, as the encoder folds one's complement
      if (sample2 < 0) begin
         mag_lin = {1'b0, s2_mag_ff} - SAMPLE_BITS'(1);
      end else begin
         mag_lin = {1'b0, s2_mag_ff};
      end
      mag12 = mag_lin[14:3];

      priority if (mag12 > 12'h7C0) seg = 3'd7;
      else if     (mag12 > 12'h3E0) seg = 3'd6;
      else if     (mag12 > 12'h1F0) seg = 3'd5;
      else if     (mag12 > 12'h0F8) seg = 3'd4;
      else if     (mag12 > 12'h07C) seg = 3'd3;
      else if     (mag12 > 12'h03E) seg = 3'd2;
      else if     (mag12 > 12'h01F) seg = 3'd1;
      else                          seg = 3'd0;

      if (seg < 3'd2) begin
         mag_sh = mag12 >> 1;
      end else begin
         mag_sh = mag12 >> seg;
      end
      alaw = {1'b0, seg, mag_sh[3:0]}
             ^ ((sample2 < 0) ? ALAW_XMASK_NEG : ALAW_XMASK_POS);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_alaw_ff   <= alaw;
         out_sample_ff <= sample2;
         out_lof_ff    <= s2_lof_ff;
         out_lot_ff    <= s2_lot_ff;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.alaw_byte     = out_alaw_ff;
   assign rsp_bus.linear_sample = out_sample_ff;
   assign rsp_bus.last_of_frame = out_lof_ff;
   assign rsp_bus.last_of_tone  = out_lot_ff;

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for sine_tone_alaw_generator_unit: sample-tick beats in,
// predicted linear and A-law samples checked beat by beat against the rsp channel.
// Depends on stag_pkg and the stag_req_if, stag_rsp_if and stag_csr_if interfaces.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import stag_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_TICKS    = 110;
   localparam int PHASES_PER_MODE = 5;
   localparam int unsigned HZ_STEP = 536871;   // 2^32 / 8000, one hertz of phase step

   typedef struct packed {
      logic [7:0]              alaw;
      logic signed [SAMPLE_BITS-1:0] lin;
      logic                    lof;
      logic                    lot;
   } tone_sample_type;

   // Predicts the sample stream from the accepted ticks and checks the rsp beats
   class tone_scoreboard_type;
      logic [AMP_BITS-1:0]    sine_q [0:QUARTER_LEN];
      bit [PHASE_BITS-1:0]    step_reg;
      bit [AMP_BITS-1:0]      amp_reg;
      bit [FRAMES_BITS-1:0]   frames_reg;
      bit [PHASE_BITS-1:0]    phase;
      bit [SIF_BITS-1:0]      pos;
      bit [FRAMES_BITS-1:0]   frames_left;
      bit                     running;
      tone_sample_type        due [$];
      int errors, ticks, checked, frame_ends, tone_ends, writes;

      function new();
         longint unsigned x, x2, term;
         longint          s, v;
         for (int k = 0; k <= QUARTER_LEN; k++) begin
            x    = (64'(k) * HALF_PI_Q30) / QUARTER_LEN;
            x2   = (x * x) >> 30;
            term = x;
            s    = longint'(x);
            // Taylor series to x^17, each term truncated
            for (int n = 1; n <= 8; n++) begin
               term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
               if (n % 2) s = s - longint'(term);
               else s = s + longint'(term);
            end
            if (s < 0) s = 0;
            v = (s * 32767 + (longint'(1) << 29)) >>> 30;
            if (v > 32767) v = 32767;
            sine_q[k] = AMP_BITS'(v);
         end
         step_reg   = PHASE_STEP_RST;
         amp_reg    = AMPLITUDE_RST;
         frames_reg = TONE_FRAMES_RST;
         phase      = '0;
         pos        = '0;
         frames_left = '0;
         running    = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] data);
         writes++;
         case (idx)
            CSR_PHASE_STEP:  step_reg   = data[PHASE_BITS-1:0];
            CSR_AMPLITUDE:   amp_reg    = data[AMP_BITS-1:0];
            CSR_TONE_FRAMES: frames_reg = data[FRAMES_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void note_tick(bit restart);
         bit [SINE_ADDR_BITS-1:0] addr;
         bit [1:0]    quad;
         int unsigned idx, tval, mag, m, seg;
         int          lin;
         bit [7:0]    code, xmask;
         bit          lof, lot;
         tone_sample_type s;
         ticks++;
         if (restart) begin
            phase       = '0;
            pos         = '0;
            frames_left = (frames_reg == 0) ? FRAMES_BITS'(1) : frames_reg;
            running     = 1'b1;
         end
         if (!running) return;

         addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
         quad = addr[SINE_ADDR_BITS-1 -: 2];
         idx  = 32'(addr[QUARTER_BITS-1:0]);
         if (quad[0]) idx = QUARTER_LEN - idx;
         tval = 32'(sine_q[idx]);
         mag  = (tval * amp_reg + 16384) >> 15;
         lin  = quad[1] ? -int'(mag) : int'(mag);

         // A-law: sign/magnitude, segment search, even bits flipped
         if (lin >= 0) begin
            m     = int'(lin) >> 3;
            xmask = ALAW_XMASK_POS;
         end else begin
            m     = (int'(-lin) - 1) >> 3;
            xmask = ALAW_XMASK_NEG;
         end
         if (m > 32'hFFF) m = 32'hFFF;
         seg = 0;
         while (seg < 7 && m > (32'h1F << seg)) seg++;
         code = 8'(seg << 4);
         if (seg < 2) code = code | 8'((m >> 1) & 32'h0F);
         else code = code | 8'((m >> seg) & 32'h0F);
         code = code ^ xmask;

         lof = (pos >= LAST_SIF);
         lot = lof && (frames_left <= 1);
         s.alaw = code;
         s.lin  = SAMPLE_BITS'(lin);
         s.lof  = lof;
         s.lot  = lot;
         due.push_back(s);

         phase = phase + step_reg;
         if (lof) begin
            pos = '0;
            if (frames_left > 0) frames_left--;
            if (frames_left == 0) running = 1'b0;
         end else begin
            pos++;
         end
      endfunction

      function void check_sample(logic [7:0] alaw, logic signed [SAMPLE_BITS-1:0] lin,
                                 logic lof, logic lot);
         tone_sample_type e;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: unexpected sample beat alaw %02h linear %0d", $time, alaw, lin);
            return;
         end
         e = due.pop_front();
         checked++;
         if (e.lof) frame_ends++;
         if (e.lot) tone_ends++;
         if (alaw !== e.alaw) begin
            errors++;
            $display("%0t: alaw_byte expected %02h actual %02h", $time, e.alaw, alaw);
         end
         if (lin !== e.lin) begin
            errors++;
            $display("%0t: linear_sample expected %0d actual %0d", $time, e.lin, lin);
         end
         if (lof !== e.lof) begin
            errors++;
            $display("%0t: last_of_frame expected %0b actual %0b", $time, e.lof, lof);
         end
         if (lot !== e.lot) begin
            errors++;
            $display("%0t: last_of_tone expected %0b actual %0b", $time, e.lot, lot);
         end
      endfunction

      function int pending();
         return due.size();
      endfunction

      function bit tone_running();
         return running;
      endfunction
   endclass

   logic clock;
   logic reset;
   int   src_idle_pct;
   int   snk_idle_pct;
   int   stall_cycles;

   stag_req_if req_if ();
   stag_rsp_if rsp_if ();
   stag_csr_if csr_if ();

   tone_scoreboard_type board = new();

   sine_tone_alaw_generator_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Sample sink: random back-pressure, check every accepted beat
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_sample(rsp_if.alaw_byte, rsp_if.linear_sample,
                            rsp_if.last_of_frame, rsp_if.last_of_tone);
   end

   // Watchdog on cycles with no beat on any channel
   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("Watchdog expired after %0d idle cycles", stall_cycles);
      $display("Verification failed");
      $finish;
   end

   task automatic send_tick(bit restart);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.restart <= restart;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_tick(restart);
   endtask

   // Back-to-back writes keep valid high; settle() drops it
   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] data);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wdata     <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      board.write_reg(idx, data);
   endtask

   task automatic settle();
      csr_if.valid <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stop ticks, let the pipeline empty, including ticks that give no beat
   task automatic quiesce();
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int  n;
      bit  restart;
      logic [31:0] step;
      logic [FRAMES_BITS-1:0] frames;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.restart   = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.reg_index = CSR_PHASE_STEP;
      csr_if.wdata     = '0;
      src_idle_pct     = 31;
      snk_idle_pct     = 62;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle tick, reset settings, quadrant peaks, zero frame count,
      // mid-tone register change, restart mid-tone, unknown index
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      quiesce();
      write_csr(CSR_PHASE_STEP, 32'h4000_0000);
      write_csr(CSR_AMPLITUDE, 32'h0000_7FFF);
      write_csr(CSR_TONE_FRAMES, 32'h0000_0000);
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      settle();
      send_tick(1'b1);
      repeat (5) send_tick(1'b0);
      quiesce();
      write_csr(CSR_PHASE_STEP, 32'h8000_0000);
      write_csr(CSR_AMPLITUDE, 32'hFFFF_8000);
      settle();
      repeat (3) send_tick(1'b0);
      quiesce();
      write_csr(CSR_PHASE_STEP, 32'h0123_4567);
      write_csr(CSR_AMPLITUDE, 32'h0000_0001);
      write_csr(CSR_TONE_FRAMES, 32'h0000_FFFF);
      settle();
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      quiesce();
      write_csr(CSR_PHASE_STEP, 32'h0C00_0000);
      write_csr(CSR_AMPLITUDE, 32'd12345);
      write_csr(CSR_TONE_FRAMES, 32'd1);
      settle();
      repeat (4) send_tick(1'b0);

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin src_idle_pct = 31; snk_idle_pct = 62; end
            1: begin src_idle_pct = 62; snk_idle_pct = 31; end
            default: begin src_idle_pct = 0; snk_idle_pct = 0; end
         endcase
         for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
            quiesce();
            case ($urandom_range(0, 4))
               0: step = $urandom_range(0, 32'h8000_0000);
               1: step = $urandom_range(0, 65535);
               2: step = 32'h8000_0000;
               3: step = '0;
               default: step = 32'($urandom_range(50, 3999)) * HZ_STEP;
            endcase
            write_csr(CSR_PHASE_STEP, step);
            case ($urandom_range(0, 3))
               0: write_csr(CSR_AMPLITUDE, {17'($urandom), 15'd0});
               1: write_csr(CSR_AMPLITUDE, {17'($urandom), 15'h7FFF});
               default: write_csr(CSR_AMPLITUDE, $urandom);
            endcase
            case ($urandom_range(0, 19))
               0: frames = '0;
               1: frames = 16'($urandom);
               2, 3, 4, 5: frames = 16'd2;
               default: frames = 16'd1;
            endcase
            write_csr(CSR_TONE_FRAMES, {16'($urandom), frames});
            if ($urandom_range(0, 2) == 0) write_csr(CSR_UNUSED, $urandom);
            settle();
            // Mostly running tones; idle ticks after a tone ends are noise
            n = 0;
            while (n < PHASE_TICKS) begin
               if (board.tone_running()) restart = ($urandom_range(0, 399) == 0);
               else restart = ($urandom_range(0, 3) == 0);
               if (restart || board.tone_running()) n++;
               send_tick(restart);
            end
         end
      end

      quiesce();
      if (board.pending() != 0) board.errors++;
      $display("Covered %0d tick beats and %0d register writes over three idling modes",
               board.ticks, board.writes);
      $display("Checked %0d samples, %0d frame ends, %0d tone ends, %0d mismatches",
               board.checked, board.frame_ends, board.tone_ends, board.errors);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/stag_pkg.sv
hw/rtl/stag_req_if.sv
hw/rtl/stag_rsp_if.sv
hw/rtl/stag_csr_if.sv
hw/rtl/sine_tone_alaw_generator_unit.sv
tb/testbench.sv
